// ===== design/qvr_pkg.sv =====
// Shared types, constants and rounding helper for the quaternion vector rotate core.
package qvr_pkg;

  localparam int unsigned QFrac   = 14;
  localparam int unsigned SqrtW   = 29;   // root bits
  localparam int unsigned RadW    = 58;   // radicand bits: S << 28
  localparam int unsigned QuotW   = 15;   // quotient bits
  localparam int unsigned NumW    = 44;   // divider remainder bits

  localparam logic [15:0] QOne    = 16'd16384;

  // rotated vector carried alongside the normalization units
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               zl;
  } rvec_t;

  // Q2.28 sum to Q1.14, ties away from zero, saturated to +-1.0
  function automatic logic signed [15:0] round_sat(input logic signed [33:0] s);
    logic [33:0] mag;
    logic [19:0] rnd;
    logic [15:0] r;
    mag = s[33] ? (~s + 34'd1) : s;
    rnd = 20'((mag + 34'd8192) >> QFrac);
    r   = (rnd > 20'(QOne)) ? QOne : rnd[15:0];
    return s[33] ? $signed(~r + 16'd1) : $signed(r);
  endfunction

endpackage

// ===== design/quaternion_vector_rotate_core.sv =====
// Top level of the quaternion vector rotate core: rotation, square root, divide, output.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid_i/in_ready_o| quat_w/x/y/z_i, vec_x/y/z_i (signed Q1.14)
//  out     | out_valid_o/out_ready_i | rot_x/y/z_o (signed Q1.14), zero_length_o
//
// One word per cycle while the output is not held; each word passes the two
// Hamilton products and squared length, the square root (one root bit per
// stage), the divider (one quotient bit per stage) and the output register.
// Reset clears only the valid bits. The whole pipeline holds while the output
// word waits, so in_ready_o follows out_ready_i whenever the output is full.
module quaternion_vector_rotate_core import qvr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] vec_x_i,
  input  logic signed [15:0] vec_y_i,
  input  logic signed [15:0] vec_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] rot_x_o,
  output logic signed [15:0] rot_y_o,
  output logic signed [15:0] rot_z_o,
  output logic               zero_length_o
);

  logic             en;
  logic             rot_vld, sq_vld, dv_vld;
  logic [RadW-1:0]  rot_n;
  rvec_t            rot_side, sq_side, dv_side;
  logic [SqrtW-1:0] sq_root;
  logic [QuotW-1:0] dv_q [3];
  logic signed [15:0] dv_c [3];
  logic signed [15:0] res  [3];

  logic               out_vld_q;
  logic signed [15:0] rx_q, ry_q, rz_q;
  logic               zl_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  qvr_rotate u_rotate (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i),
    .qw_i(quat_w_i), .qx_i(quat_x_i), .qy_i(quat_y_i), .qz_i(quat_z_i),
    .vx_i(vec_x_i), .vy_i(vec_y_i), .vz_i(vec_z_i),
    .vld_o(rot_vld), .n_o(rot_n), .side_o(rot_side)
  );

  qvr_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(rot_vld), .n_i(rot_n), .side_i(rot_side),
    .vld_o(sq_vld), .root_o(sq_root), .side_o(sq_side)
  );

  qvr_div u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(sq_vld), .len_i(sq_root), .side_i(sq_side),
    .vld_o(dv_vld), .qx_o(dv_q[0]), .qy_o(dv_q[1]), .qz_o(dv_q[2]), .side_o(dv_side)
  );

  assign dv_c[0] = dv_side.x;
  assign dv_c[1] = dv_side.y;
  assign dv_c[2] = dv_side.z;

  // saturate, restore sign, force zero for a zero-length vector
  for (genvar l = 0; l < 3; l++) begin : g_out
    logic [15:0] mag;
    assign mag    = (16'(dv_q[l]) > QOne) ? QOne : 16'(dv_q[l]);
    assign res[l] = dv_side.zl ? 16'sd0 :
                    (dv_c[l][15] ? $signed(~mag + 16'd1) : $signed(mag));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q <= res[0];
      ry_q <= res[1];
      rz_q <= res[2];
      zl_q <= dv_side.zl;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign rot_x_o       = rx_q;
  assign rot_y_o       = ry_q;
  assign rot_z_o       = rz_q;
  assign zero_length_o = zl_q;

endmodule

// ===== design/qvr_rotate.sv =====
// Two Hamilton products, rounding and squared length: six pipeline stages.
module qvr_rotate import qvr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic signed [15:0] qw_i,
  input  logic signed [15:0] qx_i,
  input  logic signed [15:0] qy_i,
  input  logic signed [15:0] qz_i,
  input  logic signed [15:0] vx_i,
  input  logic signed [15:0] vy_i,
  input  logic signed [15:0] vz_i,
  output logic               vld_o,
  output logic [RadW-1:0]    n_o,
  output rvec_t              side_o
);

  logic [5:0] vld_q;

  logic signed [15:0] q1w_q, q1x_q, q1y_q, q1z_q;
  logic signed [15:0] q2w_q, q2x_q, q2y_q, q2z_q;
  logic signed [31:0] p_q [12];
  logic signed [31:0] t_q [12];
  logic signed [15:0] aw_q, ax_q, ay_q, az_q;
  logic signed [15:0] r4x_q, r4y_q, r4z_q;
  logic signed [15:0] r5x_q, r5y_q, r5z_q;
  logic [28:0]        sqx_q, sqy_q, sqz_q;
  logic [RadW-1:0]    n_q;
  rvec_t              side_q;
  logic [29:0]        ssum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  assign ssum = 30'(sqx_q) + 30'(sqy_q) + 30'(sqz_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: q * (0, v) products
      p_q[0]  <= qx_i * vx_i;
      p_q[1]  <= qy_i * vy_i;
      p_q[2]  <= qz_i * vz_i;
      p_q[3]  <= qw_i * vx_i;
      p_q[4]  <= qy_i * vz_i;
      p_q[5]  <= qz_i * vy_i;
      p_q[6]  <= qw_i * vy_i;
      p_q[7]  <= qz_i * vx_i;
      p_q[8]  <= qx_i * vz_i;
      p_q[9]  <= qw_i * vz_i;
      p_q[10] <= qx_i * vy_i;
      p_q[11] <= qy_i * vx_i;
      q1w_q <= qw_i; q1x_q <= qx_i; q1y_q <= qy_i; q1z_q <= qz_i;
      // stage 2
      aw_q <= round_sat(-34'(p_q[0]) - 34'(p_q[1]) - 34'(p_q[2]));
      ax_q <= round_sat(34'(p_q[3]) + 34'(p_q[4]) - 34'(p_q[5]));
      ay_q <= round_sat(34'(p_q[6]) + 34'(p_q[7]) - 34'(p_q[8]));
      az_q <= round_sat(34'(p_q[9]) + 34'(p_q[10]) - 34'(p_q[11]));
      q2w_q <= q1w_q; q2x_q <= q1x_q; q2y_q <= q1y_q; q2z_q <= q1z_q;
      // stage 3: a * conj(q), conjugate folded into the signs
      t_q[0]  <= aw_q * q2x_q;
      t_q[1]  <= ax_q * q2w_q;
      t_q[2]  <= ay_q * q2z_q;
      t_q[3]  <= az_q * q2y_q;
      t_q[4]  <= aw_q * q2y_q;
      t_q[5]  <= ay_q * q2w_q;
      t_q[6]  <= az_q * q2x_q;
      t_q[7]  <= ax_q * q2z_q;
      t_q[8]  <= aw_q * q2z_q;
      t_q[9]  <= az_q * q2w_q;
      t_q[10] <= ax_q * q2y_q;
      t_q[11] <= ay_q * q2x_q;
      // stage 4
      r4x_q <= round_sat(-34'(t_q[0]) + 34'(t_q[1]) - 34'(t_q[2]) + 34'(t_q[3]));
      r4y_q <= round_sat(-34'(t_q[4]) + 34'(t_q[5]) - 34'(t_q[6]) + 34'(t_q[7]));
      r4z_q <= round_sat(-34'(t_q[8]) + 34'(t_q[9]) - 34'(t_q[10]) + 34'(t_q[11]));
      // stage 5: squares
      sqx_q <= 29'(32'(r4x_q) * 32'(r4x_q));
      sqy_q <= 29'(32'(r4y_q) * 32'(r4y_q));
      sqz_q <= 29'(32'(r4z_q) * 32'(r4z_q));
      r5x_q <= r4x_q; r5y_q <= r4y_q; r5z_q <= r4z_q;
      // stage 6: radicand in Q.56
      n_q       <= {ssum, 28'd0};
      side_q.x  <= r5x_q;
      side_q.y  <= r5y_q;
      side_q.z  <= r5z_q;
      side_q.zl <= (ssum == 30'd0);
    end
  end

  assign vld_o  = vld_q[5];
  assign n_o    = n_q;
  assign side_o = side_q;

endmodule

// ===== design/qvr_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module qvr_sqrt import qvr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [RadW-1:0]  n_i,
  input  rvec_t            side_i,
  output logic             vld_o,
  output logic [SqrtW-1:0] root_o,
  output rvec_t            side_o
);

  logic [RadW-1:0]  rem_q  [SqrtW];
  logic [SqrtW-1:0] root_q [SqrtW];
  rvec_t            side_q [SqrtW];
  logic [SqrtW-1:0] vld_q;

  for (genvar k = 0; k < SqrtW; k++) begin : g_stage
    localparam int unsigned Bit = SqrtW - 1 - k;
    logic [RadW-1:0]  rem_in;
    logic [SqrtW-1:0] root_in;
    logic             vld_in;
    rvec_t            side_in;
    logic [RadW+1:0]  trial;

    if (k == 0) begin : g_first
      assign rem_in  = n_i;
      assign root_in = '0;
      assign vld_in  = vld_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign vld_in  = vld_q[k-1];
      assign side_in = side_q[k-1];
    end

    // (2*root + 2^bit) * 2^bit
    assign trial = ((RadW+2)'(root_in) << (Bit + 1)) + ((RadW+2)'(1) << (2 * Bit));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        if ((RadW+2)'(rem_in) >= trial) begin
          rem_q[k]  <= RadW'((RadW+2)'(rem_in) - trial);
          root_q[k] <= root_in | (SqrtW'(1) << Bit);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign vld_o  = vld_q[SqrtW-1];
  assign root_o = root_q[SqrtW-1];
  assign side_o = side_q[SqrtW-1];

endmodule

// ===== design/qvr_div.sv =====
// Three-lane pipelined restoring divider: |r| * 2^28 / L, rounded, one bit per stage.
module qvr_div import qvr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [SqrtW-1:0] len_i,
  input  rvec_t            side_i,
  output logic             vld_o,
  output logic [QuotW-1:0] qx_o,
  output logic [QuotW-1:0] qy_o,
  output logic [QuotW-1:0] qz_o,
  output rvec_t            side_o
);

  logic [NumW-1:0]  rem_q  [QuotW][3];
  logic [QuotW-1:0] quo_q  [QuotW][3];
  logic [SqrtW-1:0] len_q  [QuotW];
  rvec_t            side_q [QuotW];
  logic [QuotW-1:0] vld_q;

  logic [NumW-1:0]  num0   [3];
  logic signed [15:0] comp [3];

  assign comp[0] = side_i.x;
  assign comp[1] = side_i.y;
  assign comp[2] = side_i.z;

  for (genvar l = 0; l < 3; l++) begin : g_num
    logic [15:0] mag;
    assign mag     = comp[l][15] ? (~comp[l] + 16'd1) : comp[l];
    assign num0[l] = (NumW'(mag) << 28) + NumW'(len_i >> 1);
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    localparam int unsigned Bit = QuotW - 1 - k;
    logic [NumW-1:0]  rem_in [3];
    logic [QuotW-1:0] quo_in [3];
    logic [SqrtW-1:0] len_in;
    logic             vld_in;
    rvec_t            side_in;
    logic [NumW-1:0]  dsh;

    if (k == 0) begin : g_first
      assign rem_in  = num0;
      assign quo_in  = '{default: '0};
      assign len_in  = len_i;
      assign vld_in  = vld_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign len_in  = len_q[k-1];
      assign vld_in  = vld_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign dsh = NumW'(len_in) << Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[k]  <= len_in;
        side_q[k] <= side_in;
        for (int l = 0; l < 3; l++) begin
          if (rem_in[l] >= dsh) begin
            rem_q[k][l] <= rem_in[l] - dsh;
            quo_q[k][l] <= quo_in[l] | (QuotW'(1) << Bit);
          end else begin
            rem_q[k][l] <= rem_in[l];
            quo_q[k][l] <= quo_in[l];
          end
        end
      end
    end
  end

  assign vld_o  = vld_q[QuotW-1];
  assign qx_o   = quo_q[QuotW-1][0];
  assign qy_o   = quo_q[QuotW-1][1];
  assign qz_o   = quo_q[QuotW-1][2];
  assign side_o = side_q[QuotW-1];

endmodule

// ===== tb/quaternion_vector_rotate_core_test.sv =====
// Self-checking testbench for the quaternion vector rotate core.
`timescale 1ns / 100ps

module quaternion_vector_rotate_core_test;

  typedef struct packed {
    logic signed [15:0] qw, qx, qy, qz, vx, vy, vz;
  } rot_req_t;

  typedef struct packed {
    logic signed [15:0] x, y, z;
    logic               zl;
  } unit_vec_t;

  typedef struct {
    rot_req_t  req;
    logic      known;
    unit_vec_t res;
  } stim_row_t;

  localparam int Q1        = 16384;
  localparam int NumRandom = 1400;
  localparam int DogLimit  = 20000;
  localparam int TailWait  = 120;

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [15:0] quat_w_i, quat_x_i, quat_y_i, quat_z_i;
  logic signed [15:0] vec_x_i, vec_y_i, vec_z_i;
  logic signed [15:0] rot_x_o, rot_y_o, rot_z_o;
  logic               zero_length_o;

  quaternion_vector_rotate_core u_dut (.*);

  unit_vec_t rotated_q[$];
  int        n_fail, n_sent, n_seen, idle_cyc;
  int        send_idle_pct, recv_stall_pct;
  logic      input_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Q2.28 to Q1.14, ties away from zero, clamp to +-1.0
  function automatic longint rnd_sat(longint s);
    longint m;
    m = (s < 0) ? -s : s;
    m = (m + 8192) >>> 14;
    if (m > Q1) m = Q1;
    return (s < 0) ? -m : m;
  endfunction

  function automatic longint root_floor(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint to_unit(longint c, longint len);
    longint m;
    m = (c < 0) ? -c : c;
    m = ((m <<< 28) + (len >>> 1)) / len;
    if (m > Q1) m = Q1;
    return (c < 0) ? -m : m;
  endfunction

  function automatic unit_vec_t rotate_vec(rot_req_t r);
    longint qw, qx, qy, qz, vx, vy, vz, aw, ax, ay, az, rx, ry, rz, s, len;
    unit_vec_t o;
    qw = r.qw; qx = r.qx; qy = r.qy; qz = r.qz;
    vx = r.vx; vy = r.vy; vz = r.vz;
    aw = rnd_sat(-qx * vx - qy * vy - qz * vz);
    ax = rnd_sat(qw * vx + qy * vz - qz * vy);
    ay = rnd_sat(qw * vy + qz * vx - qx * vz);
    az = rnd_sat(qw * vz + qx * vy - qy * vx);
    // multiply by the conjugate: negated vector part
    rx = rnd_sat(-aw * qx + ax * qw - ay * qz + az * qy);
    ry = rnd_sat(-aw * qy + ay * qw - az * qx + ax * qz);
    rz = rnd_sat(-aw * qz + az * qw - ax * qy + ay * qx);
    s = rx * rx + ry * ry + rz * rz;
    o = '0;
    if (s == 0) begin
      o.zl = 1'b1;
    end else begin
      len = root_floor(s <<< 28);
      o.x = 16'(to_unit(rx, len));
      o.y = 16'(to_unit(ry, len));
      o.z = 16'(to_unit(rz, len));
    end
    return o;
  endfunction

  function automatic logic signed [15:0] rand_comp();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom());
    if (k == 1) return 16'($urandom_range(0, 4)) - 16'sd2;
    if (k == 2) return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
    return 16'($urandom_range(0, 2 * Q1)) - 16'sd16384;
  endfunction

  function automatic rot_req_t rand_req();
    rot_req_t r;
    r = {rand_comp(), rand_comp(), rand_comp(), rand_comp(),
         rand_comp(), rand_comp(), rand_comp()};
    // sometimes a zero quaternion or vector
    if ($urandom_range(0, 29) == 0) r.vx = 0;
    if ($urandom_range(0, 29) == 0) {r.vy, r.vz} = '0;
    if ($urandom_range(0, 59) == 0) {r.qw, r.qx, r.qy, r.qz} = '0;
    return r;
  endfunction

  task automatic send_word(rot_req_t r, logic known, unit_vec_t res);
    unit_vec_t e;
    while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk_i);
    e = rotate_vec(r);
    if (known && e !== res) begin
      $error("directed row expectation %h disagrees with predictor %h", res, e);
      n_fail++;
    end
    {quat_w_i, quat_x_i, quat_y_i, quat_z_i, vec_x_i, vec_y_i, vec_z_i} = r;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    rotated_q.push_back(known ? res : e);
    n_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  initial begin
    stim_row_t rows[$];
    rot_req_t  r;
    rows = '{
      '{'{16384, 0, 0, 0, 16384, 0, 0}, 1'b1, '{16384, 0, 0, 1'b0}},
      '{'{16384, 0, 0, 0, 0, -16384, 0}, 1'b1, '{0, -16384, 0, 1'b0}},
      '{'{16384, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b1}},
      '{'{0, 0, 0, 0, 16384, 16384, 16384}, 1'b1, '{0, 0, 0, 1'b1}},
      '{'{0, 0, 0, 16384, 16384, 0, 0}, 1'b1, '{-16384, 0, 0, 1'b0}},
      '{'{0, 16384, 0, 0, 0, 16384, 0}, 1'b1, '{0, -16384, 0, 1'b0}},
      '{'{-16384, 0, 0, 0, 0, 0, -16384}, 1'b1, '{0, 0, -16384, 1'b0}},
      '{'{11585, 0, 0, 11585, 16384, 0, 0}, 1'b0, '0},
      '{'{16384, 16384, 16384, 16384, 16384, -16384, 16384}, 1'b0, '0},
      '{'{-16384, -16384, -16384, -16384, -16384, -16384, -16384}, 1'b0, '0},
      '{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768}, 1'b0, '0},
      '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767}, 1'b0, '0},
      '{'{32767, -32768, 21845, -21846, -1, 1, -32768}, 1'b0, '0},
      '{'{1, 0, 0, 0, 1, 0, 0}, 1'b0, '0},
      '{'{1, 1, 1, 1, 1, 1, 1}, 1'b0, '0},
      '{'{16384, 0, 0, 0, 1, 1, -1}, 1'b0, '0},
      '{'{8192, 8192, -8192, 8192, 3, -7000, 12}, 1'b0, '0}
    };
    in_valid_i = 1'b0;
    {quat_w_i, quat_x_i, quat_y_i, quat_z_i, vec_x_i, vec_y_i, vec_z_i} = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    input_done = 1'b0; n_fail = 0; n_sent = 0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) send_word(rows[i].req, rows[i].known, rows[i].res);
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int i = 0; i < NumRandom / 4; i++) begin
        r = rand_req();
        send_word(r, 1'b0, '0);
      end
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    input_done = 1'b1;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // output checks at the rising edge
  always @(posedge clk_i) begin
    unit_vec_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_seen++;
      if (rotated_q.size() == 0) begin
        $error("unexpected output word");
        n_fail++;
      end else begin
        e = rotated_q.pop_front();
        if (rot_x_o !== e.x) begin
          $error("rot_x: expected %0d, got %0d", e.x, rot_x_o); n_fail++;
        end
        if (rot_y_o !== e.y) begin
          $error("rot_y: expected %0d, got %0d", e.y, rot_y_o); n_fail++;
        end
        if (rot_z_o !== e.z) begin
          $error("rot_z: expected %0d, got %0d", e.z, rot_z_o); n_fail++;
        end
        if (zero_length_o !== e.zl) begin
          $error("zero_length: expected %0d, got %0d", e.zl, zero_length_o); n_fail++;
        end
      end
    end
  end

  initial begin
    n_seen = 0; idle_cyc = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= DogLimit) begin
        $display("watchdog: no word moved for %0d cycles", DogLimit);
        $display("end of test: mismatches");
        $finish;
      end
      if (input_done && rotated_q.size() == 0) begin
        repeat (TailWait) @(posedge clk_i);
        $display("rotated %0d vectors, %0d outputs checked, %0d failures", n_sent, n_seen,
                 n_fail);
        $display("covered identity/axis turns, zero vectors and quaternions, 16-bit extremes");
        if (n_fail == 0 && rotated_q.size() == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
design/qvr_pkg.sv
design/qvr_rotate.sv
design/qvr_sqrt.sv
design/qvr_div.sv
design/quaternion_vector_rotate_core.sv
tb/quaternion_vector_rotate_core_test.sv
